FILE: sv/light_follow_flight_controller_unit_assert.svh
// Assertion macros for the light-follow flight controller.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef LIGHT_FOLLOW_FLIGHT_CONTROLLER_UNIT_ASSERT_SVH
`define LIGHT_FOLLOW_FLIGHT_CONTROLLER_UNIT_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define LFFC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked at every clock edge out of reset.
`define LFFC_ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: sv/lffc_pkg.sv
// Shared types and constants of the light-follow flight controller.
// No dependencies; imported by lffc_decide and the top level.
package lffc_pkg;

    localparam int SENSOR_COUNT_DEF = 6;
    localparam int MAX_RESULTS      = 4;
    localparam int MAX_TURNS        = 3;

    localparam int CH_W   = 3;
    localparam int DIST_W = 16;
    localparam int LUX_W  = 16;
    localparam int TIME_W = 32;
    localparam int ARG_W  = 9;
    localparam int CNT_W  = 3;
    localparam int CFG_W  = 16;

    typedef enum logic [3:0] {
        CMD_KEEPALIVE  = 4'd0,
        CMD_LAND       = 4'd1,
        CMD_UP         = 4'd2,
        CMD_BACK       = 4'd3,
        CMD_FORWARD    = 4'd4,
        CMD_CW         = 4'd5,
        CMD_CCW        = 4'd6,
        CMD_FLIP_RIGHT = 4'd7,
        CMD_FLIP_LEFT  = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        REG_LIGHT_THRESHOLD = 3'd0,
        REG_TAKEOFF_HOLD    = 3'd1,
        REG_LAND_HOLD       = 3'd2,
        REG_TARGET_DIST     = 3'd3,
        REG_DIST_TOL        = 3'd4,
        REG_MOVE_STEP       = 3'd5,
        REG_CLIMB_STEP      = 3'd6,
        REG_TURN_MODE       = 3'd7
    } cfg_idx_t;

    localparam logic [1:0] TURN_ROTATE = 2'd0;
    localparam logic [1:0] TURN_FLIP   = 2'd1;

    localparam logic [15:0] LIGHT_THRESHOLD_RST = 16'd70;
    localparam logic [15:0] TAKEOFF_HOLD_RST    = 16'd3000;
    localparam logic [15:0] LAND_HOLD_RST       = 16'd4000;
    localparam logic [15:0] TARGET_DIST_RST     = 16'd300;
    localparam logic [15:0] DIST_TOL_RST        = 16'd50;
    localparam logic [8:0]  MOVE_STEP_RST       = 9'd60;
    localparam logic [8:0]  CLIMB_STEP_RST      = 9'd300;
    localparam logic [1:0]  TURN_MODE_RST       = TURN_ROTATE;

    typedef struct packed {
        logic [15:0] light_threshold;
        logic [15:0] takeoff_hold_ms;
        logic [15:0] land_hold_ms;
        logic [15:0] target_distance_mm;
        logic [15:0] distance_tolerance_mm;
        logic [8:0]  move_step;
        logic [8:0]  climb_step;
        logic [1:0]  turn_mode;
    } lffc_cfg_t;

    typedef struct packed {
        logic [DIST_W-1:0] best_distance;
        logic [LUX_W-1:0]  best_light;
        logic [CH_W-1:0]   best_index;
        logic              dwell_active;
        logic              airborne;
        logic [TIME_W-1:0] dwell_start_ms;
    } lffc_state_t;

    typedef struct packed {
        cmd_t [MAX_RESULTS-1:0]             cmd;
        logic [MAX_RESULTS-1:0][ARG_W-1:0]  arg;
        logic [CNT_W-1:0]                   count;
    } lffc_burst_t;

endpackage

FILE: sv/lffc_decide.sv
// Per-reading decision logic: nearest-sensor tracking and flight state machine.
// Depends on lffc_pkg. Purely combinational; the top level holds all registers.
module lffc_decide #(
    parameter int SENSOR_COUNT = lffc_pkg::SENSOR_COUNT_DEF
) (
    input  lffc_pkg::lffc_cfg_t   cfg,
    input  lffc_pkg::lffc_state_t st,
    input  logic [2:0]            channel,
    input  logic [15:0]           distance_mm,
    input  logic [15:0]           light_level,
    input  logic [31:0]           time_ms,
    output lffc_pkg::lffc_state_t st_next,
    output lffc_pkg::lffc_burst_t burst
);
    import lffc_pkg::*;

    localparam logic [3:0]      SC4   = 4'(SENSOR_COUNT);
    localparam logic [3:0]      HALF4 = 4'(SENSOR_COUNT / 2);
    localparam logic [CH_W-1:0] LAST  = CH_W'(SENSOR_COUNT - 1);

    logic              ch_valid;
    logic              take;
    logic [31:0]       elapsed;
    logic [16:0]       near_lim;
    logic [16:0]       far_lim;
    logic [3:0]        turn_raw;
    logic [3:0]        turn_cnt;
    logic              turn_right;
    logic [CNT_W-1:0]  n;

    assign ch_valid = ({1'b0, channel} < SC4);
    assign take     = (channel == '0) || (distance_mm < st.best_distance);
    assign elapsed  = time_ms - st.dwell_start_ms;

    always_comb
    begin
        st_next    = st;
        burst.cmd  = {MAX_RESULTS{CMD_KEEPALIVE}};
        burst.arg  = '0;
        n          = '0;
        near_lim   = '0;
        far_lim    = '0;
        turn_raw   = '0;
        turn_cnt   = '0;
        turn_right = 1'b0;

        if (ch_valid)
        begin
            if (take)
            begin
                st_next.best_distance = distance_mm;
                st_next.best_light    = light_level;
                st_next.best_index    = (channel == '0) ? '0 : channel;
            end

            if (channel == LAST)
            begin
                if (!st.airborne)
                begin
                    burst.cmd[0] = CMD_KEEPALIVE;
                    burst.cmd[1] = CMD_LAND;
                    n = CNT_W'(2);
                    if (st_next.best_light > cfg.light_threshold)
                    begin
                        if (!st.dwell_active)
                        begin
                            st_next.dwell_start_ms = time_ms;
                            st_next.dwell_active   = 1'b1;
                        end
                        else if (elapsed > {16'd0, cfg.takeoff_hold_ms})
                        begin
                            burst.cmd[2] = CMD_UP;
                            burst.arg[2] = cfg.climb_step;
                            n = CNT_W'(3);
                            st_next.airborne     = 1'b1;
                            st_next.dwell_active = 1'b0;
                        end
                    end
                    else
                    begin
                        st_next.dwell_active = 1'b0;
                    end
                end
                else
                begin
                    burst.cmd[0] = CMD_KEEPALIVE;
                    n = CNT_W'(1);
                    if (st_next.best_light < cfg.light_threshold)
                    begin
                        if (!st.dwell_active)
                        begin
                            st_next.dwell_start_ms = time_ms;
                            st_next.dwell_active   = 1'b1;
                        end
                        else if (elapsed > {16'd0, cfg.land_hold_ms})
                        begin
                            burst.cmd[1] = CMD_LAND;
                            n = CNT_W'(2);
                            st_next.airborne     = 1'b0;
                            st_next.dwell_active = 1'b0;
                        end
                    end
                    else
                    begin
                        st_next.dwell_active = 1'b0;
                        if (st_next.best_index == '0)
                        begin
                            // target - dist > tol, or dist - target > tol, without signs
                            near_lim = {1'b0, st_next.best_distance}
                                     + {1'b0, cfg.distance_tolerance_mm};
                            far_lim  = {1'b0, cfg.target_distance_mm}
                                     + {1'b0, cfg.distance_tolerance_mm};
                            if ({1'b0, cfg.target_distance_mm} > near_lim)
                            begin
                                burst.cmd[1] = CMD_BACK;
                                burst.arg[1] = cfg.move_step;
                                n = CNT_W'(2);
                            end
                            else if ({1'b0, st_next.best_distance} > far_lim)
                            begin
                                burst.cmd[1] = CMD_FORWARD;
                                burst.arg[1] = cfg.move_step;
                                n = CNT_W'(2);
                            end
                        end
                        else
                        begin
                            turn_right = ({1'b0, st_next.best_index} >= HALF4);
                            turn_raw   = turn_right ? (SC4 - {1'b0, st_next.best_index})
                                                    : {1'b0, st_next.best_index};
                            turn_cnt   = (turn_raw > 4'(MAX_TURNS)) ? 4'(MAX_TURNS)
                                                                    : turn_raw;
                            if (cfg.turn_mode == TURN_ROTATE)
                            begin
                                for (int k = 0; k < MAX_TURNS; k++)
                                begin
                                    if (4'(k) < turn_cnt)
                                    begin
                                        burst.cmd[k + 1] = turn_right ? CMD_CW : CMD_CCW;
                                        burst.arg[k + 1] = cfg.move_step;
                                    end
                                end
                                n = CNT_W'(1) + turn_cnt[CNT_W-1:0];
                            end
                            else if (cfg.turn_mode == TURN_FLIP)
                            begin
                                burst.cmd[1] = turn_right ? CMD_FLIP_RIGHT : CMD_FLIP_LEFT;
                                n = CNT_W'(2);
                            end
                        end
                    end
                end
            end
        end
        burst.count = n;
    end

endmodule

FILE: sv/light_follow_flight_controller_unit.sv
// Top level of the light-follow flight controller: config registers, input
// register, flight state and the result burst buffer. Depends on lffc_pkg,
// lffc_decide and light_follow_flight_controller_unit_assert.svh.
//
// Usage:
//   Sensor readings come in on the s_ stream, one transfer per sensor; channel 0
//   opens a frame, channel SENSOR_COUNT-1 closes it and triggers the flight
//   decision. Readings on other channels produce nothing; channels at or above
//   SENSOR_COUNT are dropped. Each closing reading yields a burst of 1 to 4
//   command transfers on the m_ stream, the final one marked by m_tlast.
//   A reading is registered on acceptance and decided from the input register;
//   its burst is loaded into the burst buffer as the reading leaves that
//   register, and its first command is then valid on the m_ stream.
//   Throughput: one reading per cycle, but a closing reading waits in the input
//   register while a previous burst is pending, until that burst's final transfer
//   is taken, so a frame end waits for every command of that burst (at most 4).
//   A stalled receiver holds the current command steady; other channels keep
//   flowing, but a closing reading then waits and s_tready drops.
//   Config writes (cfg_ port, always ready) take effect on the next reading and
//   are meant for idle periods. Reset restores register defaults, clears the
//   nearest-sensor tracking, dwell timer and flight state (grounded) and
//   empties the input and output stages.
module light_follow_flight_controller_unit #(
    parameter int SENSOR_COUNT = lffc_pkg::SENSOR_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // reading stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [15:0] distance_mm, [31:16] light_level, [63:32] time_ms
    input  logic [2:0]  s_tuser,   // [2:0] channel
    // command stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [8:0] argument, [11:9] nearest_channel, [12] is_flying
    output logic [3:0]  m_tuser,   // [3:0] command
    output logic        m_tlast,   // last_of_run
    // register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import lffc_pkg::*;

    localparam logic [CH_W-1:0] LAST = CH_W'(SENSOR_COUNT - 1);

    // configuration
    lffc_cfg_t cfg_reg;

    // input register
    logic              in_valid_reg;
    logic [CH_W-1:0]   in_ch_reg;
    logic [DIST_W-1:0] in_dist_reg;
    logic [LUX_W-1:0]  in_lux_reg;
    logic [TIME_W-1:0] in_time_reg;

    // tracking and flight state
    lffc_state_t state_reg;
    lffc_state_t state_next;

    // result burst
    lffc_burst_t       burst_next;
    lffc_burst_t       burst_reg;
    logic [CNT_W-1:0]  cnt_reg;     // commands still to send
    logic [1:0]        rd_reg;      // next entry to send
    logic [CH_W-1:0]   near_reg;
    logic              fly_reg;

    logic in_accept;
    logic out_pop;
    logic burst_free;
    logic advance;
    logic load;

    assign cfg_ready  = 1'b1;
    assign in_accept  = s_tvalid && s_tready;
    assign out_pop    = m_tvalid && m_tready;
    // buffer can take a new burst this cycle
    assign burst_free = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_tready);
    assign advance    = in_valid_reg && ((in_ch_reg != LAST) || burst_free);
    assign load       = advance && (burst_next.count != '0);
    assign s_tready   = !in_valid_reg || advance;

    lffc_decide #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_decide (
        .cfg         (cfg_reg),
        .st          (state_reg),
        .channel     (in_ch_reg),
        .distance_mm (in_dist_reg),
        .light_level (in_lux_reg),
        .time_ms     (in_time_reg),
        .st_next     (state_next),
        .burst       (burst_next)
    );

    // register writes; values are masked to register width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_threshold       <= LIGHT_THRESHOLD_RST;
            cfg_reg.takeoff_hold_ms       <= TAKEOFF_HOLD_RST;
            cfg_reg.land_hold_ms          <= LAND_HOLD_RST;
            cfg_reg.target_distance_mm    <= TARGET_DIST_RST;
            cfg_reg.distance_tolerance_mm <= DIST_TOL_RST;
            cfg_reg.move_step             <= MOVE_STEP_RST;
            cfg_reg.climb_step            <= CLIMB_STEP_RST;
            cfg_reg.turn_mode             <= TURN_MODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_LIGHT_THRESHOLD: cfg_reg.light_threshold       <= cfg_data;
                REG_TAKEOFF_HOLD:    cfg_reg.takeoff_hold_ms       <= cfg_data;
                REG_LAND_HOLD:       cfg_reg.land_hold_ms          <= cfg_data;
                REG_TARGET_DIST:     cfg_reg.target_distance_mm    <= cfg_data;
                REG_DIST_TOL:        cfg_reg.distance_tolerance_mm <= cfg_data;
                REG_MOVE_STEP:       cfg_reg.move_step             <= cfg_data[ARG_W-1:0];
                REG_CLIMB_STEP:      cfg_reg.climb_step            <= cfg_data[ARG_W-1:0];
                REG_TURN_MODE:       cfg_reg.turn_mode             <= cfg_data[1:0];
                default:             cfg_reg.turn_mode             <= cfg_data[1:0];
            endcase
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_ch_reg   <= s_tuser;
            in_dist_reg <= s_tdata[15:0];
            in_lux_reg  <= s_tdata[31:16];
            in_time_reg <= s_tdata[63:32];
        end
    end

    // state moves with each reading that leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // burst buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end
        else if (load)
        begin
            cnt_reg <= burst_next.count;
            rd_reg  <= '0;
        end
        else if (out_pop)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            rd_reg  <= rd_reg + 2'd1;
        end
    end

    // burst buffer payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= burst_next;
            near_reg  <= state_next.best_index;
            fly_reg   <= state_next.airborne;
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tlast  = (cnt_reg == CNT_W'(1));
    assign m_tuser  = burst_reg.cmd[rd_reg];
    assign m_tdata  = {3'd0, fly_reg, near_reg, burst_reg.arg[rd_reg]};

`include "light_follow_flight_controller_unit_assert.svh"

    `LFFC_ASSERT_ALWAYS(a_cnt_range, cnt_reg <= CNT_W'(MAX_RESULTS), "burst count out of range")
    `LFFC_ASSERT_PROP(a_load_when_free, load |-> burst_free, "burst loaded over pending commands")
    `LFFC_ASSERT_PROP(a_load_nonempty, load |=> (cnt_reg != '0), "loaded burst is empty")
    `LFFC_ASSERT_PROP(a_state_hold, !advance |=> $stable(state_reg), "state changed without a reading")
    `LFFC_ASSERT_PROP(a_takeoff_burst, $rose(state_reg.airborne) |-> $past(load), "takeoff without commands")

endmodule
